### rtl/djnz_pkg.sv
// Shared constants, codes and types of the one-instruction core.
package djnz_pkg;

    localparam int DATA_WORDS    = 256;
    localparam int PROGRAM_WORDS = 16384;

    localparam int MODE_W = 3;
    localparam int LOC_W  = 14;
    localparam int OP_W   = 9;
    localparam int TGT_W  = 15;
    localparam int BYTE_W = 8;
    localparam int PC_W   = 14;

    localparam int DATA_AW = $clog2(DATA_WORDS);
    localparam int PROG_AW = $clog2(PROGRAM_WORDS);
    localparam int PROG_W  = OP_W + TGT_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 3'd0,
        MODE_WRITE = 3'd1,
        MODE_READ  = 3'd2,
        MODE_STEP  = 3'd3,
        MODE_SETPC = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [PC_W-1:0]   program_counter;
        logic              halted;
        logic              dump_seen;
        logic              fell_through;
    } result_t;

endpackage

### rtl/djnz_ram.sv
// Generic single-port synchronous RAM with registered read data.
module djnz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

### rtl/djnz_one_instruction_core.sv
// Top level of the one-instruction (decrement, jump if nonzero) core.
//
// Input channel (in_valid / in_stall) carries one command per transaction:
// load a program word, write or read a data byte, execute one step, or set
// the program counter. Output channel (out_valid / out_stall) returns exactly
// one result per command, in order, with the program counter and halt flag
// as they stand after that command.
// Load, write, set pc, unused modes and a step while halted produce their
// result straight from the idle state; a read passes through ST_READ, a step
// on a dump word through ST_FETCH, and a decrementing step through ST_FETCH
// and ST_EXEC before its result. The next command is taken once the current
// one is done and the skid register is empty. The extra states follow from
// the program RAM read followed by a read-modify-write of the data RAM, both
// single-port with registered read data.
// Reset clears the program counter, the halt flag and, through per-byte valid
// bits, the whole data store; program memory is undefined until loaded.
// A stalled result holds on the output register; one more result parks in a
// skid register, after which in_stall stays high until the output drains.
module djnz_one_instruction_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [djnz_pkg::MODE_W-1:0]         mode,
    input  logic [djnz_pkg::LOC_W-1:0]          location,
    input  logic signed [djnz_pkg::OP_W-1:0]    operand_address,
    input  logic signed [djnz_pkg::TGT_W-1:0]   jump_target,
    input  logic [djnz_pkg::BYTE_W-1:0]         write_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [djnz_pkg::BYTE_W-1:0]         read_byte,
    output logic [djnz_pkg::PC_W-1:0]           program_counter,
    output logic                                halted,
    output logic                                dump_seen,
    output logic                                fell_through
);

    localparam int PC_W    = djnz_pkg::PC_W;
    localparam int DATA_AW = djnz_pkg::DATA_AW;
    localparam int PROG_AW = djnz_pkg::PROG_AW;
    localparam int PROG_W  = djnz_pkg::PROG_W;
    localparam int OP_W    = djnz_pkg::OP_W;
    localparam int TGT_W   = djnz_pkg::TGT_W;
    localparam int BYTE_W  = djnz_pkg::BYTE_W;

    djnz_pkg::state_t  state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              halt_reg, halt_next;
    logic [DATA_AW-1:0] daddr_reg, daddr_next;
    logic              dinrange_reg, dinrange_next;
    logic [djnz_pkg::DATA_WORDS-1:0] dvalid_reg;

    djnz_pkg::result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    djnz_pkg::result_t skid_reg, skid_next;
    logic              skid_valid_reg, skid_valid_next;

    djnz_pkg::result_t res;
    logic              res_valid;
    logic              dset;

    logic               prog_en, prog_we;
    logic [PROG_AW-1:0] prog_addr;
    logic [PROG_W-1:0]  prog_wdata, prog_rdata;
    logic               data_en, data_we;
    logic [DATA_AW-1:0] data_addr;
    logic [BYTE_W-1:0]  data_wdata, data_rdata;

    logic               accept;
    djnz_pkg::mode_t    mode_in;
    logic [OP_W-1:0]    fetched_op;
    logic [TGT_W-1:0]   fetched_tgt;
    logic               op_in_range;
    logic               loc_data_ok;
    logic               pc_ok;
    logic [PC_W:0]      pc_inc;
    logic [BYTE_W-1:0]  old_byte, dec_byte;

    djnz_ram #(.WIDTH(PROG_W), .DEPTH(djnz_pkg::PROGRAM_WORDS)) u_prog_ram (
        .clk   (clk),
        .en    (prog_en),
        .we    (prog_we),
        .addr  (prog_addr),
        .wdata (prog_wdata),
        .rdata (prog_rdata)
    );

    djnz_ram #(.WIDTH(BYTE_W), .DEPTH(djnz_pkg::DATA_WORDS)) u_data_ram (
        .clk   (clk),
        .en    (data_en),
        .we    (data_we),
        .addr  (data_addr),
        .wdata (data_wdata),
        .rdata (data_rdata)
    );

    assign in_stall = (state_reg != djnz_pkg::ST_IDLE) || skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign mode_in  = djnz_pkg::mode_t'(mode);

    assign fetched_op  = prog_rdata[PROG_W-1:TGT_W];
    assign fetched_tgt = prog_rdata[TGT_W-1:0];
    assign op_in_range = !fetched_op[OP_W-1]
                         && (32'(fetched_op[OP_W-2:0]) < djnz_pkg::DATA_WORDS);
    assign loc_data_ok = 32'(location) < djnz_pkg::DATA_WORDS;
    assign pc_ok       = !halt_reg && (32'(pc_reg) < djnz_pkg::PROGRAM_WORDS);
    assign pc_inc      = (PC_W+1)'(pc_reg) + (PC_W+1)'(1);
    assign old_byte    = dvalid_reg[daddr_reg] ? data_rdata : '0;
    assign dec_byte    = old_byte - BYTE_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            djnz_pkg::ST_IDLE:
            begin
                if (accept && mode_in == djnz_pkg::MODE_READ)
                begin
                    state_next = djnz_pkg::ST_READ;
                end
                else if (accept && mode_in == djnz_pkg::MODE_STEP && pc_ok)
                begin
                    state_next = djnz_pkg::ST_FETCH;
                end
            end
            djnz_pkg::ST_READ:
            begin
                state_next = djnz_pkg::ST_IDLE;
            end
            djnz_pkg::ST_FETCH:
            begin
                state_next = op_in_range ? djnz_pkg::ST_EXEC : djnz_pkg::ST_IDLE;
            end
            djnz_pkg::ST_EXEC:
            begin
                state_next = djnz_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pc_next       = pc_reg;
        halt_next     = halt_reg;
        daddr_next    = daddr_reg;
        dinrange_next = dinrange_reg;
        dset          = 1'b0;
        prog_en       = 1'b0;
        prog_we       = 1'b0;
        prog_addr     = location[PROG_AW-1:0];
        prog_wdata    = {operand_address, jump_target};
        data_en       = 1'b0;
        data_we       = 1'b0;
        data_addr     = location[DATA_AW-1:0];
        data_wdata    = write_byte;
        res_valid     = 1'b0;
        res.read_byte    = '0;
        res.dump_seen    = 1'b0;
        res.fell_through = 1'b0;
        unique case (state_reg)
            djnz_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid = 1'b1;
                    unique case (mode_in)
                        djnz_pkg::MODE_LOAD:
                        begin
                            prog_en = 32'(location) < djnz_pkg::PROGRAM_WORDS;
                            prog_we = 1'b1;
                        end
                        djnz_pkg::MODE_WRITE:
                        begin
                            data_en    = loc_data_ok;
                            data_we    = 1'b1;
                            dset       = loc_data_ok;
                            daddr_next = location[DATA_AW-1:0];
                        end
                        djnz_pkg::MODE_READ:
                        begin
                            res_valid     = 1'b0;
                            data_en       = 1'b1;
                            daddr_next    = location[DATA_AW-1:0];
                            dinrange_next = loc_data_ok;
                        end
                        djnz_pkg::MODE_STEP:
                        begin
                            if (pc_ok)
                            begin
                                res_valid = 1'b0;
                                prog_en   = 1'b1;
                                prog_addr = pc_reg[PROG_AW-1:0];
                            end
                            else
                            begin
                                halt_next = 1'b1;
                            end
                        end
                        djnz_pkg::MODE_SETPC:
                        begin
                            pc_next   = location;
                            halt_next = 32'(location) >= djnz_pkg::PROGRAM_WORDS;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            djnz_pkg::ST_READ:
            begin
                res_valid     = 1'b1;
                res.read_byte = dinrange_reg ? old_byte : '0;
            end
            djnz_pkg::ST_FETCH:
            begin
                if (op_in_range)
                begin
                    data_en    = 1'b1;
                    data_addr  = fetched_op[DATA_AW-1:0];
                    daddr_next = fetched_op[DATA_AW-1:0];
                end
                else
                begin
                    res_valid     = 1'b1;
                    res.dump_seen = 1'b1;
                    if (32'(pc_inc) >= djnz_pkg::PROGRAM_WORDS)
                    begin
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        pc_next = pc_inc[PC_W-1:0];
                    end
                end
            end
            djnz_pkg::ST_EXEC:
            begin
                res_valid     = 1'b1;
                res.read_byte = dec_byte;
                data_en       = 1'b1;
                data_we       = 1'b1;
                data_addr     = daddr_reg;
                data_wdata    = dec_byte;
                dset          = 1'b1;
                if (dec_byte == '0)
                begin
                    res.fell_through = 1'b1;
                    if (32'(pc_inc) >= djnz_pkg::PROGRAM_WORDS)
                    begin
                        halt_next = 1'b1;
                    end
                    else
                    begin
                        pc_next = pc_inc[PC_W-1:0];
                    end
                end
                else if (fetched_tgt[TGT_W-1]
                         || 32'(fetched_tgt[TGT_W-2:0]) >= djnz_pkg::PROGRAM_WORDS)
                begin
                    halt_next = 1'b1;
                end
                else
                begin
                    pc_next = fetched_tgt[PC_W-1:0];
                end
            end
        endcase
        res.program_counter = pc_next;
        res.halted          = halt_next;
    end

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= djnz_pkg::ST_IDLE;
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            dvalid_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            halt_reg       <= halt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (dset)
            begin
                dvalid_reg[data_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        daddr_reg    <= daddr_next;
        dinrange_reg <= dinrange_next;
        out_reg      <= out_next;
        skid_reg     <= skid_next;
    end

    assign out_valid       = out_valid_reg;
    assign read_byte       = out_reg.read_byte;
    assign program_counter = out_reg.program_counter;
    assign halted          = out_reg.halted;
    assign dump_seen       = out_reg.dump_seen;
    assign fell_through    = out_reg.fell_through;

endmodule

### rtl/djnz_chk.sv
// Port-level checker for the one-instruction core, bound to the top level.
module djnz_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [djnz_pkg::BYTE_W-1:0]         read_byte,
    input logic [djnz_pkg::PC_W-1:0]           program_counter,
    input logic                                halted,
    input logic                                dump_seen,
    input logic                                fell_through
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_byte)
            && $stable(program_counter) && $stable(halted)
            && $stable(dump_seen) && $stable(fell_through))
        else $error("stalled result changed");

    a_dump_xor_fall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(dump_seen && fell_through))
        else $error("dump and fall-through in one transaction");

    a_dump_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dump_seen |-> read_byte == '0)
        else $error("dump transaction returned a data byte");

    a_fall_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fell_through |-> read_byte == '0)
        else $error("fall-through with nonzero decremented byte");

endmodule

bind djnz_one_instruction_core djnz_chk u_djnz_chk (.*);
